// ===== hw/rtl/wsd_pkg.sv =====
// Shared types, constants and helpers for the winch stall detector.
package wsd_pkg;

    localparam int WINDOW    = 10;
    localparam int POS_W     = 12;
    localparam int CHANGE_W  = POS_W + 1;
    localparam int OUT_SUM_W = 17;
    localparam int SPEED_W   = 7;
    localparam int BLANK_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 17;

    localparam int NEED_SUM_W = $clog2(WINDOW * ((1 << CHANGE_W) - 2) + 1);
    localparam int SUM_W      = (NEED_SUM_W > OUT_SUM_W) ? NEED_SUM_W : OUT_SUM_W;
    localparam int FILL_W     = $clog2(WINDOW + 1);
    localparam int IDX_W      = $clog2(WINDOW);

    localparam logic [OUT_SUM_W-1:0] OUT_SUM_MAX = '1;
    localparam logic [BLANK_W-1:0]   TICK_MAX    = '1;

    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_DRIVE = 3'd1,
        CMD_STALL = 3'd2,
        CMD_DONE  = 3'd3,
        CMD_ABORT = 3'd4
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STALL_THRESHOLD = 2'd0,
        REG_HANG_HEIGHT     = 2'd1,
        REG_BLANK_TICKS     = 2'd2,
        REG_DRIVE_LEVEL     = 2'd3
    } cfg_reg_t;

    localparam logic [16:0]        RST_STALL_THRESHOLD = 17'd50;
    localparam logic [POS_W-1:0]   RST_HANG_HEIGHT     = 12'd900;
    localparam logic [BLANK_W-1:0] RST_BLANK_TICKS     = 8'd40;
    localparam logic [SPEED_W-1:0] RST_DRIVE_LEVEL     = 7'd127;

    // window update request from the control path
    typedef struct packed {
        logic                push;
        logic                clear;
        logic [CHANGE_W-1:0] change;
    } win_ctl_t;

    // current window contents and the preview of a push
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             full;
        logic [SUM_W-1:0] push_sum;
        logic             push_full;
    } win_stat_t;

    function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [OUT_SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] s);
        if (s > SUM_W'(OUT_SUM_MAX)) begin
            sat_sum = OUT_SUM_MAX;
        end
        else begin
            sat_sum = s[OUT_SUM_W-1:0];
        end
    endfunction

endpackage

// ===== hw/rtl/wsd_window.sv =====
// Sliding window of position changes with a running sum.
module wsd_window (
    input  logic              clk,
    input  logic              rst_n,
    input  wsd_pkg::win_ctl_t ctl,
    output wsd_pkg::win_stat_t stat
);

    logic [wsd_pkg::CHANGE_W-1:0] entry_reg [wsd_pkg::WINDOW];
    logic [wsd_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [wsd_pkg::FILL_W-1:0]   fill_reg, fill_next;
    logic [wsd_pkg::SUM_W-1:0]    sum_reg, sum_next;

    logic                         full_now;
    logic [wsd_pkg::CHANGE_W-1:0] oldest;
    logic [wsd_pkg::FILL_W-1:0]   push_fill;
    logic [wsd_pkg::SUM_W-1:0]    push_sum;

    assign full_now  = (fill_reg == wsd_pkg::FILL_W'(wsd_pkg::WINDOW));
    // the oldest entry drops out only once the window is full
    assign oldest    = full_now ? entry_reg[idx_reg] : '0;
    assign push_sum  = sum_reg - wsd_pkg::SUM_W'(oldest) + wsd_pkg::SUM_W'(ctl.change);
    assign push_fill = full_now ? fill_reg : fill_reg + 1'b1;

    assign stat.sum       = sum_reg;
    assign stat.full      = full_now;
    assign stat.push_sum  = push_sum;
    assign stat.push_full = (push_fill == wsd_pkg::FILL_W'(wsd_pkg::WINDOW));

    always_comb
    begin
        idx_next  = idx_reg;
        fill_next = fill_reg;
        sum_next  = sum_reg;
        if (ctl.clear) begin
            idx_next  = '0;
            fill_next = '0;
            sum_next  = '0;
        end
        else if (ctl.push) begin
            idx_next  = (idx_reg == wsd_pkg::IDX_W'(wsd_pkg::WINDOW - 1)) ?
                        '0 : idx_reg + 1'b1;
            fill_next = push_fill;
            sum_next  = push_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg  <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
        end
        else begin
            idx_reg  <= idx_next;
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push && !ctl.clear) begin
            entry_reg[idx_reg] <= ctl.change;
        end
    end

endmodule

// ===== hw/rtl/winch_stall_detector_top.sv =====
// Winch stall detector top level: control decisions, config and result register.
//
//  channel | signals                                         | dir
//  --------+-------------------------------------------------+-----
//  in      | in_valid, in_ready, action, left_pos, right_pos,| in
//          | abort_request                                   |
//  out     | out_valid, out_ready, command, motor_speed,     | out
//          | window_sum, window_full                         |
//  cfg     | cfg_we, cfg_index, cfg_data                     | in
//
// One item per cycle while the output register is empty or being drained; each item's
// result passes the single compare/add path through the window into the output register.
// in_ready is high whenever the output register is empty or being drained,
// so a stalled consumer holds off input only while a result waits.
// Reset loads config defaults, clears the window count and sum, and goes inactive.
module winch_stall_detector_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           action,
    input  logic [wsd_pkg::POS_W-1:0]      left_pos,
    input  logic [wsd_pkg::POS_W-1:0]      right_pos,
    input  logic                           abort_request,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [2:0]                     command,
    output logic [wsd_pkg::SPEED_W-1:0]    motor_speed,
    output logic [wsd_pkg::OUT_SUM_W-1:0]  window_sum,
    output logic                           window_full,
    input  logic                           cfg_we,
    input  logic [wsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wsd_pkg::CFG_W-1:0]      cfg_data
);

    logic [16:0]                   thresh_reg;
    logic [wsd_pkg::POS_W-1:0]     height_reg;
    logic [wsd_pkg::BLANK_W-1:0]   blank_reg;
    logic [wsd_pkg::SPEED_W-1:0]   level_reg;

    logic [wsd_pkg::POS_W-1:0]     prev_left_reg, prev_left_next;
    logic [wsd_pkg::POS_W-1:0]     prev_right_reg, prev_right_next;
    logic [wsd_pkg::BLANK_W-1:0]   tick_reg, tick_next;
    logic                          active_reg, active_next;

    logic                          out_valid_reg, out_valid_next;
    wsd_pkg::cmd_t                 cmd_reg, cmd_next;
    logic [wsd_pkg::SPEED_W-1:0]   speed_reg, speed_next;
    logic [wsd_pkg::OUT_SUM_W-1:0] wsum_reg, wsum_next;
    logic                          wfull_reg, wfull_next;

    wsd_pkg::win_ctl_t             win_ctl;
    wsd_pkg::win_stat_t            win_stat;

    logic accept;
    logic is_start, do_abort, do_done, run, pushing, stalled;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign is_start = !action;
    assign do_abort = action && active_reg && abort_request;
    assign do_done  = action && active_reg && !abort_request &&
                      (left_pos < height_reg) && (right_pos < height_reg);
    assign run      = action && active_reg && !abort_request && !do_done;
    assign pushing  = run && (tick_reg > blank_reg);
    assign stalled  = pushing && win_stat.push_full &&
                      (win_stat.push_sum < wsd_pkg::SUM_W'(thresh_reg));

    assign win_ctl.push   = accept && pushing;
    assign win_ctl.clear  = accept && (is_start || stalled);
    assign win_ctl.change = wsd_pkg::CHANGE_W'(wsd_pkg::abs_diff(prev_left_reg, left_pos)) +
                            wsd_pkg::CHANGE_W'(wsd_pkg::abs_diff(prev_right_reg, right_pos));

    wsd_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (win_ctl),
        .stat  (win_stat)
    );

    always_comb
    begin
        prev_left_next  = prev_left_reg;
        prev_right_next = prev_right_reg;
        tick_next       = tick_reg;
        active_next     = active_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        cmd_next        = cmd_reg;
        speed_next      = speed_reg;
        wsum_next       = wsum_reg;
        wfull_next      = wfull_reg;

        if (accept) begin
            out_valid_next = 1'b1;
            cmd_next       = wsd_pkg::CMD_IDLE;
            speed_next     = '0;
            wsum_next      = wsd_pkg::sat_sum(win_stat.sum);
            wfull_next     = win_stat.full;

            if (is_start) begin
                prev_left_next  = left_pos;
                prev_right_next = right_pos;
                tick_next       = '0;
                active_next     = 1'b1;
                wsum_next       = '0;
                wfull_next      = 1'b0;
            end
            else if (do_abort) begin
                cmd_next    = wsd_pkg::CMD_ABORT;
                active_next = 1'b0;
            end
            else if (do_done) begin
                cmd_next    = wsd_pkg::CMD_DONE;
                active_next = 1'b0;
            end
            else if (stalled) begin
                // window restarts; positions and tick count stay
                cmd_next   = wsd_pkg::CMD_STALL;
                wsum_next  = '0;
                wfull_next = 1'b0;
            end
            else if (run) begin
                cmd_next        = wsd_pkg::CMD_DRIVE;
                speed_next      = level_reg;
                prev_left_next  = left_pos;
                prev_right_next = right_pos;
                if (tick_reg != wsd_pkg::TICK_MAX) begin
                    tick_next = tick_reg + 1'b1;
                end
                if (pushing) begin
                    wsum_next  = wsd_pkg::sat_sum(win_stat.push_sum);
                    wfull_next = win_stat.push_full;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            thresh_reg <= wsd_pkg::RST_STALL_THRESHOLD;
            height_reg <= wsd_pkg::RST_HANG_HEIGHT;
            blank_reg  <= wsd_pkg::RST_BLANK_TICKS;
            level_reg  <= wsd_pkg::RST_DRIVE_LEVEL;
        end
        else if (cfg_we) begin
            unique case (wsd_pkg::cfg_reg_t'(cfg_index))
                wsd_pkg::REG_STALL_THRESHOLD: thresh_reg <= cfg_data[16:0];
                wsd_pkg::REG_HANG_HEIGHT:     height_reg <= cfg_data[wsd_pkg::POS_W-1:0];
                wsd_pkg::REG_BLANK_TICKS:     blank_reg  <= cfg_data[wsd_pkg::BLANK_W-1:0];
                wsd_pkg::REG_DRIVE_LEVEL:     level_reg  <= cfg_data[wsd_pkg::SPEED_W-1:0];
                default:                      thresh_reg <= thresh_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            tick_reg       <= '0;
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            prev_left_reg  <= prev_left_next;
            prev_right_reg <= prev_right_next;
            tick_reg       <= tick_next;
            active_reg     <= active_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        speed_reg <= speed_next;
        wsum_reg  <= wsum_next;
        wfull_reg <= wfull_next;
    end

    assign out_valid   = out_valid_reg;
    assign command     = cmd_reg;
    assign motor_speed = speed_reg;
    assign window_sum  = wsum_reg;
    assign window_full = wfull_reg;

endmodule

// ===== bench/tb.sv =====
// Testbench for the winch stall detector: directed and random items checked against a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                      action;
        logic [wsd_pkg::POS_W-1:0] left;
        logic [wsd_pkg::POS_W-1:0] right;
        logic                      abort_req;
    } lift_item_t;

    typedef struct {
        wsd_pkg::cmd_t                 cmd;
        logic [wsd_pkg::SPEED_W-1:0]   speed;
        logic [wsd_pkg::OUT_SUM_W-1:0] sum;
        logic                          full;
    } lift_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          action = 1'b0;
    logic [wsd_pkg::POS_W-1:0]     left_pos = '0;
    logic [wsd_pkg::POS_W-1:0]     right_pos = '0;
    logic                          abort_request = 1'b0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [2:0]                    command;
    logic [wsd_pkg::SPEED_W-1:0]   motor_speed;
    logic [wsd_pkg::OUT_SUM_W-1:0] window_sum;
    logic                          window_full;
    logic                          cfg_we = 1'b0;
    logic [wsd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [wsd_pkg::CFG_W-1:0]     cfg_data = '0;

    winch_stall_detector_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .left_pos      (left_pos),
        .right_pos     (right_pos),
        .abort_request (abort_request),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .command       (command),
        .motor_speed   (motor_speed),
        .window_sum    (window_sum),
        .window_full   (window_full),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor copy of the configuration and state
    logic [16:0]                  cfg_thresh;
    logic [wsd_pkg::POS_W-1:0]    cfg_hang;
    logic [wsd_pkg::BLANK_W-1:0]  cfg_blank;
    logic [wsd_pkg::SPEED_W-1:0]  cfg_drive;
    logic [wsd_pkg::POS_W-1:0]    last_left;
    logic [wsd_pkg::POS_W-1:0]    last_right;
    logic [wsd_pkg::CHANGE_W-1:0] change_win [wsd_pkg::WINDOW];
    int unsigned                  fill_n;
    int unsigned                  slot_n;
    int unsigned                  win_total;
    logic [wsd_pkg::BLANK_W-1:0]  tick_n;
    logic                         lift_active;

    lift_item_t   lift_items[$];
    lift_result_t winch_reports_due[$];

    logic in_fire = 1'b0;
    logic calm = 1'b0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int   tx_gap = 0;
    int   rx_gap = 0;
    int   rx_hold = 0;
    int   fail_count = 0;
    int   sent_count = 0;
    int   report_count = 0;
    int   setting_count = 0;
    int   cmd_seen [5] = '{0, 0, 0, 0, 0};

    function automatic lift_result_t winch_step(lift_item_t it);
        lift_result_t                 r;
        logic [wsd_pkg::POS_W-1:0]    dl;
        logic [wsd_pkg::POS_W-1:0]    dr;
        logic [wsd_pkg::CHANGE_W-1:0] move;
        logic                         stalled;
        r.cmd = wsd_pkg::CMD_IDLE;
        r.speed = '0;
        stalled = 1'b0;
        if (!it.action)
        begin
            // start: abort is ignored, restart allowed while active
            last_left = it.left;
            last_right = it.right;
            fill_n = 0;
            slot_n = 0;
            win_total = 0;
            tick_n = '0;
            lift_active = 1'b1;
        end
        else if (lift_active)
        begin
            if (it.abort_req)
            begin
                r.cmd = wsd_pkg::CMD_ABORT;
                lift_active = 1'b0;
            end
            else if (it.left < cfg_hang && it.right < cfg_hang)
            begin
                r.cmd = wsd_pkg::CMD_DONE;
                lift_active = 1'b0;
            end
            else
            begin
                if (tick_n > cfg_blank)
                begin
                    dl = (last_left > it.left) ? last_left - it.left : it.left - last_left;
                    dr = (last_right > it.right) ? last_right - it.right
                                                 : it.right - last_right;
                    move = wsd_pkg::CHANGE_W'(dl) + wsd_pkg::CHANGE_W'(dr);
                    if (fill_n >= wsd_pkg::WINDOW)
                        win_total -= change_win[slot_n];
                    change_win[slot_n] = move;
                    win_total += move;
                    slot_n = (slot_n + 1) % wsd_pkg::WINDOW;
                    if (fill_n < wsd_pkg::WINDOW)
                        fill_n++;
                    if (fill_n >= wsd_pkg::WINDOW && win_total < cfg_thresh)
                    begin
                        // stall pause keeps the old positions and tick count
                        stalled = 1'b1;
                        fill_n = 0;
                        slot_n = 0;
                        win_total = 0;
                        r.cmd = wsd_pkg::CMD_STALL;
                    end
                end
                if (!stalled)
                begin
                    last_left = it.left;
                    last_right = it.right;
                    r.cmd = wsd_pkg::CMD_DRIVE;
                    r.speed = cfg_drive;
                    if (tick_n != wsd_pkg::TICK_MAX)
                        tick_n++;
                end
            end
        end
        r.sum = (win_total > 32'(wsd_pkg::OUT_SUM_MAX)) ? wsd_pkg::OUT_SUM_MAX
                                                         : wsd_pkg::OUT_SUM_W'(win_total);
        r.full = (fill_n >= wsd_pkg::WINDOW);
        return r;
    endfunction

    // results are checked before the item taken at the same edge is predicted
    always @(posedge clk)
    begin
        lift_result_t want;
        lift_item_t   taken;
        in_fire = rst_n && in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (winch_reports_due.size() == 0)
            begin
                $error("result with no item outstanding: command %0d", command);
                fail_count++;
            end
            else
            begin
                want = winch_reports_due.pop_front();
                if (command !== want.cmd)
                begin
                    $error("command: expected %0d, got %0d", want.cmd, command);
                    fail_count++;
                end
                if (motor_speed !== want.speed)
                begin
                    $error("motor_speed: expected %0d, got %0d", want.speed, motor_speed);
                    fail_count++;
                end
                if (window_sum !== want.sum)
                begin
                    $error("window_sum: expected %0d, got %0d", want.sum, window_sum);
                    fail_count++;
                end
                if (window_full !== want.full)
                begin
                    $error("window_full: expected %0d, got %0d", want.full, window_full);
                    fail_count++;
                end
                report_count++;
                cmd_seen[want.cmd]++;
            end
        end
        if (in_fire)
        begin
            taken.action = action;
            taken.left = left_pos;
            taken.right = right_pos;
            taken.abort_req = abort_request;
            winch_reports_due.push_back(winch_step(taken));
        end
    end

    // sender
    always @(negedge clk)
    begin
        lift_item_t nxt;
        if (rst_n && (!in_valid || in_fire))
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (!calm && lift_items.size() > 0 && $urandom_range(0, 6) == 0)
            begin
                tx_gap = $urandom_range(0, 4);
                in_valid <= 1'b0;
            end
            else if (lift_items.size() > 0)
            begin
                nxt = lift_items.pop_front();
                in_valid <= 1'b1;
                action <= nxt.action;
                left_pos <= nxt.left;
                right_pos <= nxt.right;
                abort_request <= nxt.abort_req;
                sent_count++;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            rx_hold = 200;
        end
        if (rx_hold > 0)
        begin
            rx_hold--;
            out_ready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 6) == 0)
        begin
            rx_gap = $urandom_range(0, 4);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    task automatic add_item(logic a, int l, int r, logic ab);
        lift_item_t it;
        it.action = a;
        it.left = wsd_pkg::POS_W'(l);
        it.right = wsd_pkg::POS_W'(r);
        it.abort_req = ab;
        lift_items.push_back(it);
    endtask

    task automatic queue_noise(int n);
        repeat (n)
            add_item(1'($urandom_range(0, 1)), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
    endtask

    // start, then ticks walking both sides down at a pace that changes now and then
    task automatic queue_lift_run(int n, int abort_odds);
        int l;
        int r;
        int pace;
        int step;
        l = $urandom_range(32'(cfg_hang), 4095);
        r = $urandom_range(32'(cfg_hang), 4095);
        add_item(1'b0, l, r, 1'($urandom_range(0, 1)));
        pace = $urandom_range(0, 2);
        repeat (n)
        begin
            if ($urandom_range(0, 15) == 0)
                pace = $urandom_range(0, 2);
            step = (pace == 0) ? 1 : (pace == 1) ? 12 : 150;
            l = l + int'($urandom_range(0, 2 * step)) - step - step / 5;
            r = r + int'($urandom_range(0, 2 * step)) - step - step / 5;
            l = (l < 0) ? 0 : (l > 4095) ? 4095 : l;
            r = (r < 0) ? 0 : (r > 4095) ? 4095 : r;
            if ($urandom_range(0, 99) == 0)
                add_item(1'b0, l, r, 1'b0);
            add_item(1'b1, l, r, abort_odds != 0 && $urandom_range(1, abort_odds) == 1);
        end
    endtask

    task automatic run_phase(int target, int abort_odds);
        int start;
        start = lift_items.size();
        while (lift_items.size() - start < target)
        begin
            if ($urandom_range(0, 6) == 0)
                queue_noise($urandom_range(1, 8));
            else
                queue_lift_run($urandom_range(15, 90), abort_odds);
        end
    endtask

    // wait until every queued item is sent and every expected result is back
    task automatic wait_drained();
        while (lift_items.size() != 0 || in_valid || winch_reports_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_reg(wsd_pkg::cfg_reg_t idx, int unsigned val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= wsd_pkg::CFG_W'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            wsd_pkg::REG_STALL_THRESHOLD: cfg_thresh = 17'(val);
            wsd_pkg::REG_HANG_HEIGHT:     cfg_hang = wsd_pkg::POS_W'(val);
            wsd_pkg::REG_BLANK_TICKS:     cfg_blank = wsd_pkg::BLANK_W'(val);
            wsd_pkg::REG_DRIVE_LEVEL:     cfg_drive = wsd_pkg::SPEED_W'(val);
            default: ;
        endcase
    endtask

    task automatic set_all(int unsigned thr, int unsigned hang, int unsigned blank,
                           int unsigned drive);
        wait_drained();
        set_reg(wsd_pkg::REG_STALL_THRESHOLD, thr);
        set_reg(wsd_pkg::REG_HANG_HEIGHT, hang);
        set_reg(wsd_pkg::REG_BLANK_TICKS, blank);
        set_reg(wsd_pkg::REG_DRIVE_LEVEL, drive);
        setting_count++;
    endtask

    initial
    begin
        cfg_thresh = wsd_pkg::RST_STALL_THRESHOLD;
        cfg_hang = wsd_pkg::RST_HANG_HEIGHT;
        cfg_blank = wsd_pkg::RST_BLANK_TICKS;
        cfg_drive = wsd_pkg::RST_DRIVE_LEVEL;
        last_left = '0;
        last_right = '0;
        fill_n = 0;
        slot_n = 0;
        win_total = 0;
        tick_n = '0;
        lift_active = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        setting_count = 1;

        // reset configuration: idle tick, abort, height edges, restart
        add_item(1'b1, 0, 0, 1'b0);
        add_item(1'b0, 4095, 4095, 1'b1);
        add_item(1'b1, 4095, 4095, 1'b0);
        add_item(1'b1, 0, 4095, 1'b0);
        add_item(1'b1, 4095, 0, 1'b0);
        add_item(1'b1, 2000, 2000, 1'b1);
        add_item(1'b1, 12'hAAA, 12'h555, 1'b1);
        add_item(1'b0, 4095, 4095, 1'b0);
        add_item(1'b1, 899, 899, 1'b0);
        add_item(1'b0, 900, 900, 1'b0);
        add_item(1'b1, 900, 899, 1'b0);
        add_item(1'b0, 2000, 2000, 1'b0);

        // no blanking and a huge threshold: stall as soon as the window fills
        set_all(131071, 900, 0, 0);
        add_item(1'b0, 2048, 2048, 1'b0);
        repeat (12) add_item(1'b1, 2048, 2048, 1'b0);
        add_item(1'b1, 0, 4095, 1'b0);

        set_all(32'(wsd_pkg::RST_STALL_THRESHOLD), 32'(wsd_pkg::RST_HANG_HEIGHT),
                32'(wsd_pkg::RST_BLANK_TICKS), 32'(wsd_pkg::RST_DRIVE_LEVEL));
        run_phase(260, 60);
        hold_req = 1'b1;

        set_all(0, 4095, 0, 0);
        run_phase(150, 60);

        // tick count saturates before stall detection may start
        set_all(131071, 0, 254, 127);
        queue_lift_run(330, 0);
        run_phase(80, 400);

        repeat (2)
        begin
            set_all($urandom_range(0, 1500), $urandom_range(200, 2500), $urandom_range(0, 20),
                    $urandom_range(0, 127));
            run_phase(230, 80);
        end

        set_all($urandom_range(0, 1500), $urandom_range(200, 2500), $urandom_range(0, 20),
                $urandom_range(0, 127));
        calm = 1'b1;
        run_phase(200, 80);

        wait_drained();
        repeat (5) @(posedge clk);
        $display("Checked %0d results from %0d items over %0d register settings.",
                 report_count, sent_count, setting_count);
        $display("Commands: idle %0d, drive %0d, stall %0d, done %0d, abort %0d; %0d mismatches.",
                 cmd_seen[wsd_pkg::CMD_IDLE], cmd_seen[wsd_pkg::CMD_DRIVE],
                 cmd_seen[wsd_pkg::CMD_STALL], cmd_seen[wsd_pkg::CMD_DONE],
                 cmd_seen[wsd_pkg::CMD_ABORT], fail_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d results outstanding.", winch_reports_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
